[hw/rtl/lfwd_pkg.sv]
// ----------------------------------------------------------------------------
// lfwd_pkg: shared constants for the least-free worker dispatcher
// Field widths, register map and the default worker table size.
// ----------------------------------------------------------------------------
package lfwd_pkg;

  // payload field widths
  localparam int DUR_W    = 31;
  localparam int TIME_W   = 48;
  localparam int WORKER_W = 4;

  // configuration register
  localparam int REG_W    = 5;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam logic [1:0] REG_WORKER_COUNT = 2'd0;
  localparam logic [REG_W-1:0] WORKER_COUNT_RST = 5'd1;

  // default table size
  localparam int MAX_WORKERS_DEF = 16;

endpackage

[hw/rtl/lfwd_ram.sv]
// ----------------------------------------------------------------------------
// lfwd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfwd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lfwd_seq.sv]
// ----------------------------------------------------------------------------
// lfwd_seq: scan sequencer with one shared comparator
// Walks the free-time table one entry per cycle, keeps the earliest free
// worker, then writes back its advanced free time and loads the result word.
// ----------------------------------------------------------------------------
module lfwd_seq #(
  parameter int MAX_WORKERS = 16,
  parameter int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lfwd_pkg::REG_W-1:0]     worker_count,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  logic [lfwd_pkg::DUR_W-1:0]     duration,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [lfwd_pkg::WORKER_W-1:0]  worker,
  output logic [lfwd_pkg::TIME_W-1:0]    start_time,
  output logic                           ram_we,
  output logic [IDX_W-1:0]               ram_waddr,
  output logic [lfwd_pkg::TIME_W-1:0]    ram_wdata,
  output logic [IDX_W-1:0]               ram_raddr,
  input  logic [lfwd_pkg::TIME_W-1:0]    ram_rdata
);
  import lfwd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
  localparam int WIDE_W = (CNT_W > REG_W) ? CNT_W : REG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state;
  logic [DUR_W-1:0]       dur;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       rd_tag;
  logic                   rd_last;
  logic                   rd_vld;
  logic [IDX_W-1:0]       best_idx;
  logic [TIME_W-1:0]      best_time;
  logic [MAX_WORKERS-1:0] valid;

  logic                   job_fire;
  logic                   done_fire;
  logic [WIDE_W-1:0]      wc_ext;
  logic [WIDE_W-1:0]      max_ext;
  logic [WIDE_W-1:0]      last_wide;
  logic [TIME_W-1:0]      entry_time;
  logic                   take;
  logic [TIME_W:0]        sum;
  logic [TIME_W-1:0]      next_time;

  assign job_ready = (state == S_IDLE);
  assign job_fire  = job_valid && job_ready;
  assign done_fire = (state == S_DONE) && (!result_valid || result_ready);

  // clamp the worker count to 1..MAX_WORKERS, kept as the last index
  assign wc_ext  = WIDE_W'(worker_count);
  assign max_ext = WIDE_W'(MAX_WORKERS);
  always_comb begin
    if (wc_ext == '0) begin
      last_wide = '0;
    end else if (wc_ext > max_ext) begin
      last_wide = max_ext - WIDE_W'(1);
    end else begin
      last_wide = wc_ext - WIDE_W'(1);
    end
  end

  // read entry 0 on accept, then the running index during the scan
  assign ram_raddr = (state == S_SCAN) ? rd_idx : '0;

  // entries never written read as zero
  assign entry_time = rd_vld ? ram_rdata : '0;
  assign take       = (rd_tag == '0) || (entry_time < best_time);

  // saturating advance of the chosen free time
  assign sum       = {1'b0, best_time} + (TIME_W + 1)'(dur);
  assign next_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  assign ram_we    = done_fire;
  assign ram_waddr = best_idx;
  assign ram_wdata = next_time;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_fire) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan index, tag of the word in flight and its valid bit
  always_ff @(posedge clk) begin
    rd_vld <= valid[ram_raddr];
    if (job_fire) begin
      dur      <= duration;
      last_idx <= last_wide[IDX_W-1:0];
      rd_tag   <= '0;
      rd_last  <= (last_wide == '0);
      rd_idx   <= IDX_W'(1);
    end else if (state == S_SCAN && !rd_last) begin
      rd_tag  <= rd_idx;
      rd_last <= (rd_idx == last_idx);
      rd_idx  <= rd_idx + IDX_W'(1);
    end
  end

  // keep the earliest free worker, lowest index on ties
  always_ff @(posedge clk) begin
    if (state == S_SCAN && take) begin
      best_idx  <= rd_tag;
      best_time <= entry_time;
    end
  end

  // mark entries once written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (done_fire) begin
      valid[best_idx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      worker     <= WORKER_W'(best_idx);
      start_time <= best_time;
    end
  end

endmodule

[hw/rtl/least_free_worker_dispatch.sv]
// ----------------------------------------------------------------------------
// least_free_worker_dispatch: assign each job to the earliest free worker
// Keeps a free time per worker, picks the smallest (lowest index on ties),
// reports worker and start time, and advances that free time by the job.
//
//   channel   signals                                  direction
//   job       job_valid, job_ready, duration           in
//   result    result_valid, result_ready, worker,      out
//             start_time
//   config    psel, penable, pwrite, paddr, pwdata,    APB
//             prdata, pready
//
// A job is accepted and starts the first table read; the scan then passes
// the n active workers, n being worker_count clamped to 1..MAX_WORKERS,
// through the single comparator one by one; the last step writes back the
// free time and loads the result word.
// Reset clears the free-time valid bits, so every worker starts free at zero.
// A result waiting on result_ready holds the write-back stage; a new job is
// taken as soon as the previous result word is loaded.
// ----------------------------------------------------------------------------
module least_free_worker_dispatch #(
  parameter int MAX_WORKERS = lfwd_pkg::MAX_WORKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lfwd_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfwd_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfwd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  logic [lfwd_pkg::DUR_W-1:0]     duration,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [lfwd_pkg::WORKER_W-1:0]  worker,
  output logic [lfwd_pkg::TIME_W-1:0]    start_time
);
  import lfwd_pkg::*;

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [REG_W-1:0]  worker_count;
  logic [1:0]        reg_sel;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= WORKER_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_WORKER_COUNT) begin
      worker_count <= pwdata[REG_W-1:0];
    end
  end

  // register read
  assign prdata = (reg_sel == REG_WORKER_COUNT) ? PDATA_W'(worker_count) : '0;

  lfwd_seq #(
    .MAX_WORKERS (MAX_WORKERS),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .worker_count (worker_count),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .duration     (duration),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .worker       (worker),
    .start_time   (start_time),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  lfwd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_WORKERS),
    .AW    (IDX_W)
  ) u_free_time (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the least-free worker dispatcher
// Drives jobs through the valid/ready channel and the APB register port,
// keeps a scoreboard model of the per-worker free times, and checks every
// result word (worker and start time) in order against it. Covers the
// worker_count limits, ignored register slots, resizing between drained
// batches, random traffic under three idle mixes, a long receiver hold-off
// and runs of full-length jobs that push free times into the upper bits.
// ----------------------------------------------------------------------------
module tb_top;
  import lfwd_pkg::*;

  typedef struct packed {
    logic [WORKER_W-1:0] worker;
    logic [TIME_W-1:0]   start;
  } assignment_t;

  localparam int REG_STRIDE = 4;
  localparam logic [PADDR_W-1:0] ADDR_WORKER_COUNT =
    PADDR_W'(int'(REG_WORKER_COUNT) * REG_STRIDE);
  localparam int ADDR_SLOTS = (1 << PADDR_W) / REG_STRIDE;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;
  // full-length jobs on one worker, enough to carry its free time past 32 bits
  localparam int LONG_JOBS = 16;
  localparam int SETTLE_CYCLES = MAX_WORKERS_DEF + 4;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic job_valid = 1'b0;
  logic job_ready;
  logic [DUR_W-1:0] duration = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [WORKER_W-1:0] worker;
  logic [TIME_W-1:0] start_time;

  // scoreboard model state
  logic [TIME_W-1:0] free_at [MAX_WORKERS_DEF];
  logic [REG_W-1:0]  model_count;
  assignment_t       assign_q[$];
  assignment_t       due;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int err_count = 0;
  int jobs_sent = 0;
  int results_seen = 0;
  int count_writes = 0;

  least_free_worker_dispatch dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .job_valid(job_valid), .job_ready(job_ready), .duration(duration),
    .result_valid(result_valid), .result_ready(result_ready),
    .worker(worker), .start_time(start_time)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pick the earliest free worker among the active ones and advance it
  function automatic assignment_t assign_job(input logic [DUR_W-1:0] dur);
    int n;
    int best;
    assignment_t res;
    logic [TIME_W:0] sum;
    n = model_count;
    if (n == 0) n = 1;
    if (n > MAX_WORKERS_DEF) n = MAX_WORKERS_DEF;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (free_at[i] < free_at[best]) best = i;
    end
    res.worker = best[WORKER_W-1:0];
    res.start = free_at[best];
    sum = {1'b0, free_at[best]} + dur;
    free_at[best] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    return res;
  endfunction

  // Mostly short jobs so ties and reordering happen, some full-range ones
  function automatic logic [DUR_W-1:0] random_duration();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    else if (sel < 15) return DUR_MAX;
    else if (sel < 40) return DUR_W'($urandom_range(3));
    else if (sel < 80) return DUR_W'($urandom_range(255));
    else return DUR_W'($urandom);
  endfunction

  function automatic logic [REG_W-1:0] pick_count();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: return '0;
        1: return REG_W'(1);
        2: return REG_W'(MAX_WORKERS_DEF);
        default: return '1;
      endcase
    end
    return REG_W'($urandom_range((1 << REG_W) - 1));
  endfunction

  // Offer one job word; log the prediction once it is taken
  task automatic send_job(input logic [DUR_W-1:0] dur);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      job_valid <= 1'b0;
      @(negedge clk);
    end
    job_valid <= 1'b1;
    duration <= dur;
    do @(posedge clk); while (!job_ready);
    assign_q.push_back(assign_job(dur));
    jobs_sent++;
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic drain();
    @(negedge clk);
    job_valid <= 1'b0;
    while (assign_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_WORKER_COUNT) model_count = data[REG_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_count_reg();
    logic [PDATA_W-1:0] rd;
    apb_read(ADDR_WORKER_COUNT, rd);
    if (rd !== PDATA_W'(model_count)) begin
      err_count++;
      $error("worker_count readback: expected %0d, got %0d", model_count, rd);
    end
  endtask

  // Write the count with random junk above the field, then read it back
  task automatic set_worker_count(input logic [REG_W-1:0] cnt);
    logic [PDATA_W-1:0] data;
    data = PDATA_W'($urandom);
    data[REG_W-1:0] = cnt;
    apb_write(ADDR_WORKER_COUNT, data);
    count_writes++;
    check_count_reg();
  endtask

  // Drive result_ready: a requested hold-off wins over random stalls
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (assign_q.size() == 0) begin
        err_count++;
        $error("result word with no job pending: worker %0d start_time %0h",
               worker, start_time);
      end else begin
        due = assign_q.pop_front();
        results_seen++;
        if (worker !== due.worker) begin
          err_count++;
          $error("worker mismatch: expected %0d, got %0d", due.worker, worker);
        end
        if (start_time !== due.start) begin
          err_count++;
          $error("start_time mismatch: expected %0h, got %0h", due.start, start_time);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    check_count_reg();
    send_job('0);
    send_job(DUR_MAX);
    send_job(DUR_W'(5));
    settle();
  endtask

  // Zero acts as one worker, anything above the table as the whole table
  task automatic test_count_limits();
    set_worker_count('0);
    send_job(DUR_W'(7));
    send_job('0);
    settle();
    set_worker_count('1);
    repeat (4) send_job(DUR_W'(3));
    settle();
    set_worker_count(REG_W'(MAX_WORKERS_DEF));
    repeat (3) send_job(DUR_W'(1));
    settle();
  endtask

  // Writes to unused register slots must leave the count alone
  task automatic test_spare_registers();
    for (int idx = int'(REG_WORKER_COUNT) + 1; idx < ADDR_SLOTS; idx++) begin
      apb_write(PADDR_W'(idx * REG_STRIDE), PDATA_W'($urandom));
    end
    check_count_reg();
    send_job(DUR_W'(2));
    send_job(DUR_MAX);
    settle();
  endtask

  // Shrink and grow without clearing: parked workers rejoin the search
  task automatic test_count_resize();
    set_worker_count(REG_W'(3));
    repeat (4) send_job(DUR_W'($urandom_range(20)));
    settle();
    set_worker_count(REG_W'(MAX_WORKERS_DEF));
    repeat (4) send_job(DUR_W'($urandom_range(20)));
    settle();
    set_worker_count(REG_W'(2));
    repeat (2) send_job(DUR_W'($urandom_range(20)));
    settle();
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n_jobs);
    int left;
    int batch;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    left = n_jobs;
    while (left > 0) begin
      batch = $urandom_range(15, 90);
      if (batch > left) batch = left;
      repeat (batch) send_job(random_duration());
      left -= batch;
      settle();
      set_worker_count(pick_count());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(20, 73, 620);
    run_random_phase(73, 20, 620);
    run_random_phase(0, 0, 620);
  endtask

  // Hold the receiver off while jobs keep coming, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_worker_count(REG_W'(4));
    rx_hold_left = HOLD_CYCLES;
    repeat (40) send_job(random_duration());
    settle();
    rx_idle_pct = 50;
    repeat (30) send_job(random_duration());
    settle();
  endtask

  // Pile full-length jobs on one worker to drive its free time up fast
  task automatic test_long_jobs();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_worker_count(REG_W'(1));
    repeat (LONG_JOBS) send_job(DUR_MAX);
    settle();
    set_worker_count(REG_W'(2));
    repeat (3) send_job(DUR_MAX);
    settle();
    set_worker_count(REG_W'(MAX_WORKERS_DEF));
    repeat (4) send_job(random_duration());
    settle();
  endtask

  initial begin
    model_count = WORKER_COUNT_RST;
    for (int i = 0; i < MAX_WORKERS_DEF; i++) free_at[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_count_limits();
    test_spare_registers();
    test_count_resize();
    test_random_traffic();
    test_backpressure();
    test_long_jobs();

    settle();
    if (assign_q.size() != 0) begin
      err_count++;
      $error("%0d result words never arrived", assign_q.size());
    end
    $display("summary: %0d jobs dispatched, %0d result words checked, %0d count writes",
             jobs_sent, results_seen, count_writes);
    $display("summary: count limits, spare slots, resizing, backpressure, long jobs");
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[least_free_worker_dispatch.f]
hw/rtl/lfwd_pkg.sv
hw/rtl/lfwd_ram.sv
hw/rtl/lfwd_seq.sv
hw/rtl/least_free_worker_dispatch.sv
sim/tb_top.sv
